/* rtl/csvf_pkg.sv */
// Shared types, constants, arithmetic helpers and elaboration-time table helpers for the cascaded stereo SVF.
package csvf_pkg;

	localparam int SAMPLE_BITS      = 24;
	localparam int COEF_W           = 26;
	localparam int SHIFT_IO         = 29 - SAMPLE_BITS;
	localparam int STAGES_DEF       = 4;
	localparam int TANH_ENTRIES_DEF = 256;
	localparam int CFG_IDX_W        = 3;
	localparam int MODE_W           = 3;
	localparam int OPND_W           = 34;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A3     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AK     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_K      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STAGES = 3'd6;

	// Filter modes
	localparam logic [MODE_W-1:0] MODE_LP      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HP      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BP      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_NOTCH   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PEAK    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ALLPASS = 3'd5;
	localparam logic [MODE_W-1:0] MODE_BYPASS  = 3'd6;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
	} out_t;

	// One command to the shared multiply-accumulate unit
	typedef struct packed {
		logic                     en;
		logic                     clr;
		logic                     sub;
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
		logic signed [63:0]       addend;
	} mac_op_t;

	// Round half up at bit 24
	function automatic logic signed [63:0] rnd24(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd8388608;
		return t >>> 24;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Shift-subtract division, used only when building the tanh table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// exp(-16z) in Q.31 from a truncated series for exp(-z), then squared four times
	function automatic logic [63:0] exp_neg_q31(input logic [63:0] z);
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        prod;
		term = 64'd1 << 31;
		sum  = 64'sd2147483648;
		for (int n = 1; n < 16; n++) begin
			prod = term * z;
			term = udiv64(prod >> 31, 64'(n));
			if (n % 2 == 1)
				sum = sum - $signed(term);
			else
				sum = sum + $signed(term);
		end
		if (sum < 0)
			sum = '0;
		if (sum > 64'sd2147483648)
			sum = 64'sd2147483648;
		term = $unsigned(sum);
		for (int q = 0; q < 4; q++)
			term = (term * term + (64'd1 << 30)) >> 31;
		return term;
	endfunction

	// Table point i of n on [0,4], Q4.28
	function automatic logic signed [31:0] tanh_point(input int i, input int n);
		logic [63:0] z;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] q;
		z   = udiv64(64'(i) << 30, 64'(n));
		e   = exp_neg_q31(z);
		den = (64'd1 << 31) + e;
		num = ((64'd1 << 31) - e) << 28;
		q   = udiv64(num + (den >> 1), den);
		return $signed(q[31:0]);
	endfunction

endpackage

/* rtl/csvf_mac.sv */
// Shared multiply-accumulate unit with a registered accumulator.
module csvf_mac (
	input  logic                     clk,
	input  logic                     arst_n,
	input  csvf_pkg::mac_op_t        op,
	output logic signed [63:0]       acc
);
	import csvf_pkg::*;

	logic signed [2*OPND_W-1:0] prod;
	logic signed [63:0]         term;
	logic signed [63:0]         base;
	logic signed [63:0]         acc_q;

	// One product per enabled cycle, added to the accumulator (or zero) and the addend
	always_comb begin
		prod = op.a * op.b;
		term = op.sub ? -prod[63:0] : prod[63:0];
		base = op.clr ? 64'sd0 : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op.en) begin
			acc_q <= base + term + op.addend;
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/csvf_tanh.sv */
// Tanh point table with registered read of two neighbouring points.
module csvf_tanh #(
	parameter int TANH_ENTRIES = csvf_pkg::TANH_ENTRIES_DEF,
	localparam int IW = $clog2(TANH_ENTRIES + 1)
) (
	input  logic               clk,
	input  logic               rd_en,
	input  logic [IW-1:0]      idx,
	output logic signed [31:0] lo,
	output logic signed [31:0] hi
);
	import csvf_pkg::*;

	typedef logic signed [31:0] tab_t [0:TANH_ENTRIES];

	function automatic tab_t build_tab();
		tab_t t;
		for (int i = 0; i <= TANH_ENTRIES; i++)
			t[i] = tanh_point(i, TANH_ENTRIES);
		return t;
	endfunction

	localparam tab_t TAB = build_tab();

	logic [IW-1:0]      idx_hi;
	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;

	// Upper neighbour clamps at the last point
	always_comb begin
		idx_hi = (idx == IW'(TANH_ENTRIES)) ? idx : IW'(idx + 1'b1);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			lo_q <= TAB[idx];
			hi_q <= TAB[idx_hi];
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;

endmodule

/* rtl/cascaded_stereo_state_variable_filter.sv */
// Top level: registers, integrator store and sequencer of the cascaded stereo SVF.
//
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   in_data   (left_in, right_in)
//  out      source     out_valid/out_stall out_data  (left_out, right_out)
//  cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each section and channel runs the steps S_LOAD to S_WB on the one
// multiply-accumulate unit, for min(stage_count, STAGES) sections; an item
// is taken only in S_IDLE, so the next one waits until the last has left
// the output stage.
// Reset clears the integrators and handshake state and presets the registers.
// in_stall is high while an item is in work; a held result in the output
// register only delays the final hand-over of the next one.
module cascaded_stereo_state_variable_filter #(
	parameter int STAGES       = csvf_pkg::STAGES_DEF,
	parameter int TANH_ENTRIES = csvf_pkg::TANH_ENTRIES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  csvf_pkg::in_t                          in_data,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output csvf_pkg::out_t                         out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [csvf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [csvf_pkg::COEF_W-1:0]            cfg_data
);
	import csvf_pkg::*;

	localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int CW = $clog2(STAGES + 1);
	localparam int IW = $clog2(TANH_ENTRIES + 1);
	localparam int DEPTH = 2 * STAGES;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_A1V3, S_AKC1, S_TIDX, S_TLOOK, S_TINT, S_V0,
		S_A1C1, S_A3V3, S_A2C1, S_KV1, S_WB, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [COEF_W-1:0] a1_q, a2_q, a3_q, ak_q, k_q;
	logic [MODE_W-1:0] mode_q;
	logic [2:0]        scount_q;

	// Integrator store, one entry per section and channel
	logic signed [31:0] ic1_q [DEPTH];
	logic signed [31:0] ic2_q [DEPTH];

	// Working registers
	logic signed [31:0] x_q [2];
	logic               ch_q;
	logic [CW-1:0]      stg_q;
	logic signed [31:0] c1_q, c2_q;
	logic signed [32:0] v3_q;
	logic signed [31:0] v0_q, v1_q, v2_q;
	logic               neg_q, big_q;
	logic [29:0]        f_q;
	logic               out_valid_q;
	out_t               out_data_q;

	mac_op_t            op;
	logic signed [63:0] acc;
	logic [IW-1:0]      tidx;
	logic               t_rd;
	logic signed [31:0] t_lo, t_hi;

	logic [SW:0]               eidx;
	logic signed [63:0]        t0, mag, rsum, kv, ysum;
	logic                      big;
	logic signed [31:0]        r32;
	logic [CW-1:0]             nlim;
	logic signed [OPND_W-1:0]  ea1, ea2, ea3, eak, ek, ev3, ec1, ev1;
	logic signed [32:0]        v3_n;
	logic signed [31:0]        y, ic1_n, ic2_n;
	out_t                      out_n;

	csvf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	csvf_tanh #(.TANH_ENTRIES(TANH_ENTRIES)) u_tanh (
		.clk   (clk),
		.rd_en (t_rd),
		.idx   (tidx),
		.lo    (t_lo),
		.hi    (t_hi)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Operand extension and derived values
	always_comb begin
		eidx  = {stg_q[SW-1:0], ch_q};
		nlim  = ({1'b0, scount_q} > 4'(STAGES)) ? CW'(STAGES) : CW'(scount_q);
		ea1   = $signed(OPND_W'(a1_q));
		ea2   = $signed(OPND_W'(a2_q));
		ea3   = $signed(OPND_W'(a3_q));
		eak   = $signed(OPND_W'(ak_q));
		ek    = $signed(OPND_W'(k_q));
		ev3   = OPND_W'(v3_q);
		ec1   = OPND_W'(c1_q);
		ev1   = OPND_W'(v1_q);
		v3_n  = 33'(x_q[ch_q]) - 33'(ic2_q[eidx]);
		t0    = rnd24(acc);
		mag   = t0[63] ? -t0 : t0;
		big   = (mag >= 64'sd1073741824);
		rsum  = 64'(t_lo) + (acc >>> 30);
		r32   = rsum[31:0];
		kv    = rnd24(acc);
		ic1_n = sat32(64'(v1_q) * 2 - 64'(c1_q));
		ic2_n = sat32(64'(v2_q) * 2 - 64'(c2_q));
		case (mode_q)
			MODE_LP:      ysum = 64'(v2_q);
			MODE_HP:      ysum = 64'(v0_q);
			MODE_BP:      ysum = 64'(v1_q);
			MODE_NOTCH:   ysum = 64'(v2_q) + 64'(v0_q);
			MODE_PEAK:    ysum = 64'(v2_q) - 64'(v0_q);
			MODE_ALLPASS: ysum = 64'(v2_q) + 64'(v0_q) - kv;
			default:      ysum = 64'(x_q[ch_q]);
		endcase
		y = sat32(ysum);
	end

	// Output conversion: round off the extra fraction bits and saturate
	function automatic logic signed [SAMPLE_BITS-1:0] to_out(input logic signed [31:0] v);
		logic signed [32:0] s;
		logic signed [32:0] r;
		s = 33'(v) + 33'sd16;
		r = s >>> SHIFT_IO;
		if (r > 33'sd8388607)
			return 24'sh7fffff;
		else if (r < -33'sd8388608)
			return 24'sh800000;
		else
			return r[SAMPLE_BITS-1:0];
	endfunction

	always_comb begin
		out_n.left_out  = to_out(x_q[0]);
		out_n.right_out = to_out(x_q[1]);
	end

	// Command to the shared unit and table read, per sequencer step
	always_comb begin
		op        = '0;
		t_rd      = 1'b0;
		tidx      = big_q ? IW'(TANH_ENTRIES) : acc[30 +: IW];
		unique case (state_q)
			S_A1V3: begin
				op.en = 1'b1; op.clr = 1'b1; op.a = ea1; op.b = ev3;
			end
			S_AKC1: begin
				op.en = 1'b1; op.sub = 1'b1; op.a = eak; op.b = ec1;
			end
			S_TIDX: begin
				op.en = 1'b1; op.clr = 1'b1;
				op.a = big ? '0 : $signed(OPND_W'(mag[29:0]));
				op.b = $signed(OPND_W'(TANH_ENTRIES));
			end
			S_TLOOK: begin
				t_rd = 1'b1;
			end
			S_TINT: begin
				op.en = 1'b1; op.clr = 1'b1;
				op.a = OPND_W'(t_hi) - OPND_W'(t_lo);
				op.b = $signed(OPND_W'(f_q));
				op.addend = 64'sd536870912;
			end
			S_V0: begin
				op.en = 1'b1; op.clr = 1'b1; op.a = ea2; op.b = ev3;
			end
			S_A1C1: begin
				op.en = 1'b1; op.a = ea1; op.b = ec1;
			end
			S_A3V3: begin
				op.en = 1'b1; op.clr = 1'b1; op.a = ea3; op.b = ev3;
				op.addend = 64'(c2_q) <<< 24;
			end
			S_A2C1: begin
				op.en = 1'b1; op.a = ea2; op.b = ec1;
			end
			S_KV1: begin
				op.en = 1'b1; op.clr = 1'b1; op.a = ek; op.b = ev1;
			end
			S_IDLE, S_LOAD, S_WB, S_OUT: begin
				op = '0;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a1_q     <= '0;
			a2_q     <= '0;
			a3_q     <= '0;
			ak_q     <= '0;
			k_q      <= '0;
			mode_q   <= MODE_BYPASS;
			scount_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_A1:     a1_q     <= cfg_data;
				REG_A2:     a2_q     <= cfg_data;
				REG_A3:     a3_q     <= cfg_data;
				REG_AK:     ak_q     <= cfg_data;
				REG_K:      k_q      <= cfg_data;
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_STAGES: scount_q <= cfg_data[2:0];
				default:    ;
			endcase
		end
	end

	// Sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ch_q        <= 1'b0;
			stg_q       <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				ic1_q[i] <= '0;
				ic2_q[i] <= '0;
			end
		end else begin
			// Result taken; the output stage reloads it itself
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q[0] <= 32'(in_data.left_in) <<< SHIFT_IO;
						x_q[1] <= 32'(in_data.right_in) <<< SHIFT_IO;
						ch_q   <= 1'b0;
						stg_q  <= '0;
						state_q <= (nlim == '0) ? S_OUT : S_LOAD;
					end
				end
				S_LOAD: begin
					c1_q    <= ic1_q[eidx];
					c2_q    <= ic2_q[eidx];
					v3_q    <= v3_n;
					state_q <= S_A1V3;
				end
				S_A1V3:  state_q <= S_AKC1;
				S_AKC1:  state_q <= S_TIDX;
				S_TIDX: begin
					neg_q   <= t0[63];
					big_q   <= big;
					state_q <= S_TLOOK;
				end
				S_TLOOK: begin
					f_q     <= big_q ? 30'd0 : acc[29:0];
					state_q <= S_TINT;
				end
				S_TINT:  state_q <= S_V0;
				S_V0: begin
					v0_q    <= neg_q ? -r32 : r32;
					state_q <= S_A1C1;
				end
				S_A1C1:  state_q <= S_A3V3;
				S_A3V3: begin
					v1_q    <= sat32(rnd24(acc));
					state_q <= S_A2C1;
				end
				S_A2C1:  state_q <= S_KV1;
				S_KV1: begin
					v2_q    <= sat32(rnd24(acc));
					state_q <= S_WB;
				end
				S_WB: begin
					ic1_q[eidx] <= ic1_n;
					ic2_q[eidx] <= ic2_n;
					x_q[ch_q]   <= y;
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						ch_q <= 1'b0;
						if (CW'(stg_q + 1'b1) == nlim) begin
							state_q <= S_OUT;
						end else begin
							stg_q   <= CW'(stg_q + 1'b1);
							state_q <= S_LOAD;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_data_q  <= out_n;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
